// ===== rtl/tlpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared codes, constants and controller/datapath signal groups of the
// two-level page walk unit.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  localparam int STORE_DEPTH = 4096;  // bytes in the memory and in the disk image

  localparam logic [1:0] OP_WR_MEM    = 2'd0;
  localparam logic [1:0] OP_WR_DISK   = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_BAD_DIR   = 3'd1;
  localparam logic [2:0] ST_BAD_TABLE = 3'd2;
  localparam logic [2:0] ST_NO_PAGE   = 3'd3;
  localparam logic [2:0] ST_WRITE     = 3'd4;

  localparam logic [11:0] BASE_RESET = 12'hD80;
  localparam logic [7:0]  BAD_MARK   = 8'h7F;
  localparam logic [6:0]  FRAME_MARK = 7'h7F;

  // controller -> datapath
  typedef struct packed {
    logic take;      // request accepted this cycle
    logic step_tab;  // directory byte on the read port
    logic step_dat;  // table byte on the read port
    logic step_fin;  // data byte on the read port
    logic load_out;  // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic translate;
    logic bad_dir;
    logic bad_tab;
    logic no_page;
  } stat_t;

endpackage

// ===== rtl/tlpw_if.sv =====
// ----------------------------------------------------------------------------
// tlpw interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlpw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] store_address;
  logic [7:0]  store_byte;
  logic [14:0] virtual_address;

  modport source (output valid, opcode, store_address, store_byte, virtual_address,
                  input ready);
  modport sink   (input valid, opcode, store_address, store_byte, virtual_address,
                  output ready);
endinterface

interface tlpw_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  directory_entry;
  logic [7:0]  table_entry;
  logic [11:0] physical_address;
  logic [7:0]  data_value;

  modport source (output valid, status, directory_entry, table_entry,
                  physical_address, data_value, input ready);
  modport sink   (input valid, status, directory_entry, table_entry,
                  physical_address, data_value, output ready);
endinterface

interface tlpw_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/tlpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpw_ctrl
// Walk sequencer: accepts a request, steps the datapath through the reads,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module tlpw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  tlpw_pkg::stat_t stat_i,
  output tlpw_pkg::cmd_t  cmd_o
);
  import tlpw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAB  = 3'd1;
  localparam logic [2:0] S_DAT  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = stat_i.translate ? S_TAB : S_RESP;
        end
      end
      S_TAB: begin
        cmd_o.step_tab = 1'b1;
        state_d        = stat_i.bad_dir ? S_RESP : S_DAT;
      end
      S_DAT: begin
        cmd_o.step_dat = 1'b1;
        state_d        = (stat_i.bad_tab || stat_i.no_page) ? S_RESP : S_FIN;
      end
      S_FIN: begin
        cmd_o.step_fin = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/tlpw_datapath.sv =====
// ----------------------------------------------------------------------------
// tlpw_datapath
// Memory and disk arrays, directory base register, walk registers and the
// output register.
// ----------------------------------------------------------------------------
module tlpw_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [11:0]     cfg_data_i,
  input  logic [1:0]      opcode_i,
  input  logic [11:0]     store_address_i,
  input  logic [7:0]      store_byte_i,
  input  logic [14:0]     virtual_address_i,
  input  tlpw_pkg::cmd_t  cmd_i,
  output tlpw_pkg::stat_t stat_o,
  output logic [2:0]      status_o,
  output logic [7:0]      directory_entry_o,
  output logic [7:0]      table_entry_o,
  output logic [11:0]     physical_address_o,
  output logic [7:0]      data_value_o
);
  import tlpw_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0]  mem_q  [STORE_DEPTH];
  logic [7:0]  disk_q [STORE_DEPTH];
  logic [7:0]  mem_rd_q, disk_rd_q;
  logic [11:0] base_q;
  logic [14:0] va_q;

  logic [2:0]  st_q;
  logic [7:0]  de_q, te_q, dv_q;
  logic [11:0] pa_q;

  logic [2:0]  out_st_q;
  logic [7:0]  out_de_q, out_te_q, out_dv_q;
  logic [11:0] out_pa_q;

  logic        mem_we, disk_we, rd_en;
  logic [11:0] rd_addr, dir_addr;
  logic [7:0]  te_now;

  assign dir_addr = base_q + {7'd0, virtual_address_i[14:10]};
  // table byte comes from memory or disk as the directory byte says
  assign te_now   = de_q[7] ? mem_rd_q : disk_rd_q;

  assign mem_we  = cmd_i.take && (opcode_i == OP_WR_MEM);
  assign disk_we = cmd_i.take && (opcode_i == OP_WR_DISK);
  assign rd_en   = (cmd_i.take && stat_o.translate) || cmd_i.step_tab || cmd_i.step_dat;

  always_comb begin
    if (cmd_i.step_tab) begin
      rd_addr = {mem_rd_q[6:0], va_q[9:5]};
    end else if (cmd_i.step_dat) begin
      rd_addr = {te_now[6:0], va_q[4:0]};
    end else begin
      rd_addr = dir_addr;
    end
  end

  assign stat_o.translate = (opcode_i == OP_TRANSLATE);
  assign stat_o.bad_dir   = (mem_rd_q == BAD_MARK);
  assign stat_o.bad_tab   = (te_now == BAD_MARK);
  assign stat_o.no_page   = (te_now[6:0] == FRAME_MARK);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[store_address_i[AW-1:0]] <= store_byte_i;
    end
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (disk_we) begin
      disk_q[store_address_i[AW-1:0]] <= store_byte_i;
    end
    if (rd_en) begin
      disk_rd_q <= disk_q[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_data_i;
    end
  end

  // walk registers; fields not reached by the walk stay zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      va_q <= virtual_address_i;
      st_q <= ST_WRITE;
      de_q <= '0;
      te_q <= '0;
      pa_q <= '0;
      dv_q <= '0;
    end
    if (cmd_i.step_tab) begin
      de_q <= mem_rd_q;
      if (stat_o.bad_dir) begin
        st_q <= ST_BAD_DIR;
      end
    end
    if (cmd_i.step_dat) begin
      te_q <= te_now;
      if (stat_o.bad_tab) begin
        st_q <= ST_BAD_TABLE;
      end else begin
        pa_q <= {te_now[6:0], va_q[4:0]};
        if (stat_o.no_page) begin
          st_q <= ST_NO_PAGE;
        end
      end
    end
    if (cmd_i.step_fin) begin
      st_q <= ST_FOUND;
      dv_q <= te_q[7] ? mem_rd_q : disk_rd_q;
    end
    if (cmd_i.load_out) begin
      out_st_q <= st_q;
      out_de_q <= de_q;
      out_te_q <= te_q;
      out_pa_q <= pa_q;
      out_dv_q <= dv_q;
    end
  end

  assign status_o           = out_st_q;
  assign directory_entry_o  = out_de_q;
  assign table_entry_o      = out_te_q;
  assign physical_address_o = out_pa_q;
  assign data_value_o       = out_dv_q;

endmodule

// ===== rtl/two_level_page_walk_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_page_walk_unit
// Two-level page table walk over a byte memory and a byte disk image.
// ----------------------------------------------------------------------------
// One request at a time. A memory or disk write goes straight to the response
// state; a full translation ends after the data read, a bad directory entry
// after the directory read, a bad table entry or missing page after the table
// read. The walk takes three dependent reads through the single registered
// read port of each array, each address coming from the byte before.
// The result sits in an output register, so the next request is taken while
// it waits. The arrays hold no reset value: reading a byte never written gives
// an undefined answer. Configuration (the directory base) is always ready and
// should only be written while no request is in flight.
// ----------------------------------------------------------------------------
module two_level_page_walk_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  tlpw_req_if.sink       req_i,
  tlpw_rsp_if.source     rsp_o,
  tlpw_cfg_if.sink       cfg_i
);
  import tlpw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // base register takes a write every cycle it is offered
  assign cfg_i.ready = 1'b1;

  tlpw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tlpw_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_i.valid),
    .cfg_data_i         (cfg_i.data),
    .opcode_i           (req_i.opcode),
    .store_address_i    (req_i.store_address),
    .store_byte_i       (req_i.store_byte),
    .virtual_address_i  (req_i.virtual_address),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .status_o           (rsp_o.status),
    .directory_entry_o  (rsp_o.directory_entry),
    .table_entry_o      (rsp_o.table_entry),
    .physical_address_o (rsp_o.physical_address),
    .data_value_o       (rsp_o.data_value)
  );

endmodule

// ===== rtl/tlpw_checker.sv =====
// ----------------------------------------------------------------------------
// tlpw_checker
// Port-level checks of the page walk unit, bound to the top level.
// ----------------------------------------------------------------------------
module tlpw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [1:0] req_opcode_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_status_i
);
  import tlpw_pkg::*;

  // one request in flight: a translation keeps the input closed after it is accepted
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_opcode_i == OP_TRANSLATE))
      |=> !req_ready_i ##1 !req_ready_i)
    else $error("request taken during a walk");

  // any accepted request closes the input in the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("back-to-back request accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i <= ST_WRITE))
    else $error("response status out of range");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i)))
    else $error("stalled response dropped or changed");

endmodule

bind two_level_page_walk_unit tlpw_checker u_tlpw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status)
);
